>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the hash table block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/chht_pkg.sv
// ----------------------------------------------------------------------------
// chht_pkg
// shared types and constants of the coordinate hash table
// ----------------------------------------------------------------------------
package chht_pkg;

    localparam int ENTRY_BITS = 8;
    localparam logic [31:0] HASH_MUL_X = 32'd7907;
    localparam logic [31:0] HASH_MUL_Z = 32'd4391;

    localparam logic FUNC_LOOKUP   = 1'b0;
    localparam logic FUNC_FIND_ADD = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HOME,
        ST_PROBE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic hash_en;
        logic home_load;
        logic step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic hit;
        logic empty;
        logic out_busy;
    } status_t;

endpackage

>>> src/coord_hash_table_find_or_add.sv
// ----------------------------------------------------------------------------
// coord_hash_table_find_or_add
// open-addressing coordinate hash table with linear probing, find or add
// ----------------------------------------------------------------------------
// Each input word carries a signed (x, z) grid key in section units and a
// func bit (lookup only, or find or add). The home slot is the low bits of
// (x*7907 xor z*4391) in 32-bit wrapping arithmetic; probing walks forward
// one slot per cycle, wrapping, until it meets the key or an empty slot.
// A hit returns found with the stored entry index; a find-or-add miss stores
// the key in the empty slot with the next entry index in insertion order,
// unless only one empty slot is left, in which case full_res is set.
// Every request returns exactly one result word. After reset the
// block runs a clearing pass over the slot ram, one slot a cycle, and in_ready
// stays low until every slot is cleared. Afterwards a request is taken in
// the idle state, then the hash multipliers run, then the home slot is
// read, then there is one ram read per slot probed (at least one) until
// the walk ends and the block is ready to accept the next word. The
// single read port of the slot ram sets the probe rate. The result sits in an
// output register, so a new word can be accepted while the last result waits;
// the probe walk only holds at its final slot while that register is full and out_ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module coord_hash_table_find_or_add #(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic signed [KEY_BITS-1:0]      key_x,
    input  logic signed [KEY_BITS-1:0]      key_z,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic                            inserted,
    output logic                            full_res,
    output logic [chht_pkg::ENTRY_BITS-1:0] entry_index
);

    import chht_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    chht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // slot store, hash and result register
    chht_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (func),
        .key_x       (key_x),
        .key_z       (key_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .inserted    (inserted),
        .full_res    (full_res),
        .entry_index (entry_index)
    );

    // at most one outcome flag per result word
    `ASSERT_IMP(a_one_outcome, clk, rst_n, out_valid, $onehot0({found, inserted, full_res}))

    // a request never finishes in the cycle after it is taken
    `ASSERT_NXT(a_no_early_finish, clk, rst_n, in_valid && in_ready, !cmd.finish && !in_ready)

    // a finish never overwrites a result still waiting at the output
    `ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.finish, !(out_valid && !out_ready))

endmodule

>>> src/chht_ram.sv
// ----------------------------------------------------------------------------
// chht_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module chht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/chht_ctrl.sv
// ----------------------------------------------------------------------------
// chht_ctrl
// sequencer: clearing pass, hash, home slot read, linear probe walk
// ----------------------------------------------------------------------------
module chht_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chht_pkg::status_t status,
    output chht_pkg::cmd_t    cmd
);

    import chht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash_en = 1'b1;
                state_next  = ST_HOME;
            end
            ST_HOME:
            begin
                cmd.home_load = 1'b1;
                state_next    = ST_PROBE;
            end
            ST_PROBE:
            begin
                if (status.hit || status.empty)
                begin
                    // hold the slot until the output register is free
                    if (!status.out_busy)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> src/chht_dp.sv
// ----------------------------------------------------------------------------
// chht_dp
// key registers, hash, probe pointer, slot ram, entry counter, result word
// ----------------------------------------------------------------------------
module chht_dp #(
    parameter int SLOTS    = 256,
    parameter int KEY_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  chht_pkg::cmd_t                      cmd,
    output chht_pkg::status_t                   status,
    input  logic                                func,
    input  logic signed [KEY_BITS-1:0]          key_x,
    input  logic signed [KEY_BITS-1:0]          key_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic                                inserted,
    output logic                                full_res,
    output logic [chht_pkg::ENTRY_BITS-1:0]     entry_index
);

    import chht_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int SW = 1 + 2 * KEY_BITS + ENTRY_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    logic                       func_reg;
    logic signed [KEY_BITS-1:0] key_x_reg;
    logic signed [KEY_BITS-1:0] key_z_reg;
    logic [31:0]                prod_x_reg;
    logic [31:0]                prod_z_reg;
    logic [31:0]                kx_ext;
    logic [31:0]                kz_ext;
    logic [31:0]                hash_word;
    logic [AW-1:0]              slot_reg;
    logic [AW-1:0]              slot_next;
    logic [AW-1:0]              clr_reg;
    logic [AW-1:0]              count_reg;

    logic                       out_valid_reg;
    logic                       found_reg;
    logic                       inserted_reg;
    logic                       full_reg;
    logic [ENTRY_BITS-1:0]      index_reg;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [SW-1:0]              wr_data;
    logic [AW-1:0]              rd_addr;
    logic [SW-1:0]              rd_data;

    logic                       slot_valid;
    logic [KEY_BITS-1:0]        slot_kx;
    logic [KEY_BITS-1:0]        slot_kz;
    logic [ENTRY_BITS-1:0]      slot_entry;
    logic                       hit;
    logic                       is_full;
    logic                       do_insert;

    // slot word: valid, x, z, entry
    assign slot_valid = rd_data[SW-1];
    assign slot_kx    = rd_data[SW-2 -: KEY_BITS];
    assign slot_kz    = rd_data[SW-2-KEY_BITS -: KEY_BITS];
    assign slot_entry = rd_data[ENTRY_BITS-1:0];

    assign hit       = slot_valid && (slot_kx == key_x_reg) && (slot_kz == key_z_reg);
    assign is_full   = (count_reg == LAST_SLOT);
    assign do_insert = cmd.finish && !hit && (func_reg == FUNC_FIND_ADD) && !is_full;

    assign kx_ext    = 32'(key_x_reg);
    assign kz_ext    = 32'(key_z_reg);
    assign hash_word = prod_x_reg ^ prod_z_reg;

    always_comb
    begin
        if (cmd.home_load)
        begin
            slot_next = hash_word[AW-1:0];
        end
        else if (cmd.step)
        begin
            slot_next = slot_reg + AW'(1);
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    assign rd_addr = slot_next;
    assign wr_en   = cmd.clear_en || do_insert;
    assign wr_addr = cmd.clear_en ? clr_reg : slot_reg;
    assign wr_data = cmd.clear_en ? '0
                                  : {1'b1, key_x_reg, key_z_reg, ENTRY_BITS'(count_reg)};

    chht_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            key_x_reg <= key_x;
            key_z_reg <= key_z;
        end
        if (cmd.hash_en)
        begin
            prod_x_reg <= kx_ext * HASH_MUL_X;
            prod_z_reg <= kz_ext * HASH_MUL_Z;
        end
        slot_reg <= slot_next;
        if (cmd.finish)
        begin
            found_reg    <= hit;
            inserted_reg <= do_insert;
            full_reg     <= !hit && (func_reg == FUNC_FIND_ADD) && is_full;
            if (hit)
            begin
                index_reg <= slot_entry;
            end
            else if (do_insert)
            begin
                index_reg <= ENTRY_BITS'(count_reg);
            end
            else
            begin
                index_reg <= '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (do_insert)
            begin
                count_reg <= count_reg + AW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last = (clr_reg == LAST_SLOT);
    assign status.hit      = hit;
    assign status.empty    = !slot_valid;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign inserted    = inserted_reg;
    assign full_res    = full_reg;
    assign entry_index = index_reg;

endmodule
